// ----- rtl/tag_presence_tracker_top_assert.svh -----
// Assertion macros shared by the tracker checker.
`ifndef TAG_PRESENCE_TRACKER_TOP_ASSERT_SVH
`define TAG_PRESENCE_TRACKER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define TPT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("tracker check failed");
// Next-cycle implication checked outside reset.
`define TPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tracker check failed");
`endif

// ----- rtl/tpt_pkg.sv -----
// Package with constants and types of the tag presence tracker.
package tpt_pkg;
  localparam int unsigned TagSlots = 16;

  localparam logic [31:0] KeyRssiBits  = 32'hff000000;
  localparam logic [31:0] KeyNoRssi    = 32'h00ffffff;
  localparam logic [31:0] KeyLevelBits = 32'h00ff0000;
  localparam logic [31:0] KeyNoLevel   = 32'hff00ffff;
  localparam logic [31:0] KeyAll       = 32'hffffffff;

  localparam logic [1:0] ModeBeacon = 2'd0;
  localparam logic [1:0] ModeAge    = 2'd1;
  localparam logic [1:0] ModeAck    = 2'd2;
  localparam logic [1:0] ModeQuery  = 2'd3;

  localparam logic [2:0] StNone     = 3'd0;
  localparam logic [2:0] StNew      = 3'd1;
  localparam logic [2:0] StReported = 3'd2;
  localparam logic [2:0] StConf     = 3'd3;
  localparam logic [2:0] StFadeRep  = 3'd4;
  localparam logic [2:0] StFadeConf = 3'd5;
  localparam logic [2:0] StGone     = 3'd6;
  localparam logic [2:0] StSummary  = 3'd7;

  localparam logic [2:0] KNothing = 3'd0;
  localparam logic [2:0] KReport  = 3'd1;
  localparam logic [2:0] KFull    = 3'd2;
  localparam logic [2:0] KBadSlot = 3'd3;
  localparam logic [2:0] KEmpty   = 3'd4;

  localparam logic [1:0] RegLocal   = 2'd0;
  localparam logic [1:0] RegMaster  = 2'd1;
  localparam logic [1:0] RegOffset  = 2'd2;
  localparam logic [1:0] RegGranule = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LOAD, S_ACT, S_OUT
  } fsm_e;
endpackage

// ----- rtl/tag_presence_tracker_top.sv -----
// Top level of the tag presence tracker: slot table, scan sequencer and result register.
//
//  channel | signals                         | direction
//  in      | in_valid_i / in_ready_o         | items to the block
//  out     | out_valid_o / out_ready_i       | results from the block
//  cfg     | cfg_we_i, cfg_idx_i, cfg_data_i | register writes
//
// One compare unit walks the slot table one slot a cycle, looking for a masked match,
// the first free slot and the occupancy. Aging skips the walk. The slot table sits
// in flip-flops with one valid bit per slot that reset clears, so no clearing pass
// is needed. A finished result waits in the output register; the next item is
// taken meanwhile.
module tag_presence_tracker_top #(
  parameter int unsigned TAG_SLOTS = tpt_pkg::TagSlots
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] now_seconds_i,
  input  logic [7:0]  rssi_i,
  input  logic [7:0]  power_level_i,
  input  logic [15:0] tag_address_i,
  input  logic [31:0] lookup_key_i,
  input  logic [7:0]  slot_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic [31:0] report_tag_key_o,
  output logic [31:0] report_timestamp_o,
  output logic [2:0]  report_state_o,
  output logic [15:0] report_count_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  localparam int unsigned IW = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TAG_SLOTS + 1);

  // Slot table; an entry whose valid bit is clear reads as all zero.
  logic [TAG_SLOTS-1:0] vld_q;
  logic [31:0] key_mem [TAG_SLOTS];
  logic [2:0]  st_mem  [TAG_SLOTS];
  logic [15:0] cnt_mem [TAG_SLOTS];
  logic [31:0] ev_mem  [TAG_SLOTS];
  logic [31:0] last_mem[TAG_SLOTS];

  logic [15:0] local_q, master_q, gran_q;
  logic [31:0] offset_q;

  tpt_pkg::fsm_e state_q, state_d;
  logic [1:0]  mode_q;
  logic [31:0] now_q, key_q, mask_q;
  logic [7:0]  sidx_q;
  logic [IW-1:0] ptr_q;
  logic [CW-1:0] occ_q;
  logic found_q, free_q;
  logic [IW-1:0] fidx_q, freeidx_q;

  // Slot working copy
  logic [31:0] wkey_q, wev_q, wlast_q;
  logic [2:0]  wst_q;
  logic [15:0] wcnt_q;

  logic        ovalid_q;
  logic [2:0]  okind_q, ost_q;
  logic [31:0] okey_q, ots_q;
  logic [15:0] ocnt_q;

  // Read of the slot under the scan pointer.
  logic        rv;
  logic [31:0] rkey;
  assign rv   = vld_q[ptr_q];
  assign rkey = rv ? key_mem[ptr_q] : 32'd0;

  logic [31:0] in_key, in_mask;
  always_comb begin
    in_key = (mode_i == tpt_pkg::ModeBeacon) ? {rssi_i, power_level_i, tag_address_i}
                                             : lookup_key_i;
    in_mask = tpt_pkg::KeyAll;
    if ((in_key & tpt_pkg::KeyRssiBits) == 32'd0) in_mask &= tpt_pkg::KeyNoRssi;
    if ((in_key & tpt_pkg::KeyLevelBits) == 32'd0) in_mask &= tpt_pkg::KeyNoLevel;
  end

  logic last_slot;
  assign last_slot = (ptr_q == IW'(TAG_SLOTS - 1));
  assign in_ready_o = (state_q == tpt_pkg::S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tpt_pkg::S_IDLE: if (in_valid_i) begin
        state_d = (mode_i == tpt_pkg::ModeAge) ? tpt_pkg::S_LOAD : tpt_pkg::S_SCAN;
      end
      tpt_pkg::S_SCAN: if (last_slot) state_d = tpt_pkg::S_LOAD;
      tpt_pkg::S_LOAD: state_d = tpt_pkg::S_ACT;
      tpt_pkg::S_ACT:  state_d = tpt_pkg::S_OUT;
      tpt_pkg::S_OUT:  if (!ovalid_q || out_ready_i) state_d = tpt_pkg::S_IDLE;
      default: state_d = tpt_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tpt_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Decision taken in the action cycle on the working copy.
  logic        bad, hit, wr_en, do_clear;
  logic [IW-1:0] widx;
  logic [31:0] nkey, nev, nlast;
  logic [2:0]  nst, kind;
  logic [15:0] ncnt;
  logic [31:0] tkey, tts;
  logic [2:0]  tst;
  logic [15:0] tcnt;
  logic        rep, pre_rep, nomaster, ismaster;
  logic [31:0] age;

  always_comb begin
    nomaster = (master_q == 16'd0);
    ismaster = (master_q == local_q);
    age      = now_q - wlast_q;
    bad      = (mode_q == tpt_pkg::ModeAge) && (32'(sidx_q) >= TAG_SLOTS);
    hit      = found_q;
    widx     = (mode_q == tpt_pkg::ModeAge) ? sidx_q[IW-1:0] : fidx_q;
    wr_en    = 1'b0;
    do_clear = 1'b0;
    nkey = wkey_q; nst = wst_q; ncnt = wcnt_q; nev = wev_q; nlast = wlast_q;
    kind = tpt_pkg::KNothing;
    rep  = 1'b0;
    pre_rep = 1'b0;
    tkey = 32'd0; tts = 32'd0; tst = tpt_pkg::StNone; tcnt = 16'd0;
    unique case (mode_q)
      tpt_pkg::ModeBeacon: begin
        if (!hit) begin
          if (free_q) begin
            widx = freeidx_q; wr_en = 1'b1;
            nkey = key_q; nst = tpt_pkg::StNew; ncnt = 16'd0;
            nev = now_q; nlast = now_q;
          end else begin
            kind = tpt_pkg::KFull;
          end
        end else begin
          wr_en = 1'b1;
          case (wst_q)
            tpt_pkg::StNew: begin
              pre_rep = 1'b1;
              nst = ismaster ? tpt_pkg::StConf : tpt_pkg::StReported;
              ncnt = 16'd0; nlast = now_q;
            end
            tpt_pkg::StReported: begin
              nlast = now_q;
              if (ismaster) begin
                pre_rep = 1'b1;
                nst = tpt_pkg::StConf; ncnt = 16'd0;
              end else begin
                rep = 1'b1;
              end
            end
            tpt_pkg::StConf: nlast = now_q;
            tpt_pkg::StFadeRep: begin
              nst = tpt_pkg::StReported; ncnt = 16'd0; nlast = now_q;
            end
            tpt_pkg::StFadeConf: begin
              nst = tpt_pkg::StConf; ncnt = 16'd0; nlast = now_q;
            end
            tpt_pkg::StGone: begin
              nst = tpt_pkg::StNew; ncnt = 16'd0; nlast = now_q; nev = now_q;
            end
            default: begin
              wr_en = 1'b0; kind = tpt_pkg::KEmpty;
            end
          endcase
        end
      end
      tpt_pkg::ModeAge: begin
        if (bad) begin
          kind = tpt_pkg::KBadSlot;
        end else if (wkey_q != 32'd0 && age >= {16'd0, gran_q}) begin
          wr_en = 1'b1;
          case (wst_q)
            tpt_pkg::StNew: do_clear = 1'b1;
            tpt_pkg::StGone: rep = 1'b1;
            tpt_pkg::StReported: begin
              nst = tpt_pkg::StFadeRep; ncnt = 16'd0; nlast = now_q;
            end
            tpt_pkg::StConf: begin
              nst = tpt_pkg::StFadeConf; ncnt = 16'd0; nlast = now_q;
            end
            tpt_pkg::StFadeRep, tpt_pkg::StFadeConf: begin
              nst = tpt_pkg::StGone; ncnt = 16'd0; nlast = now_q; nev = now_q;
              rep = 1'b1;
              do_clear = ismaster || nomaster;
            end
            default: begin
              wr_en = 1'b0; kind = tpt_pkg::KEmpty;
            end
          endcase
        end
      end
      tpt_pkg::ModeAck: begin
        if (hit) begin
          wr_en = 1'b1;
          case (wst_q)
            tpt_pkg::StReported: begin
              nst = tpt_pkg::StConf; ncnt = 16'd0; nlast = now_q;
            end
            tpt_pkg::StFadeRep: begin
              nst = tpt_pkg::StFadeConf; ncnt = 16'd0; nlast = now_q;
            end
            tpt_pkg::StGone: do_clear = 1'b1;
            default: wr_en = 1'b0;
          endcase
        end
      end
      default: begin
        if (key_q != 32'd0 && hit) begin
          rep = 1'b1; wr_en = 1'b1;
        end else if (!nomaster) begin
          kind = tpt_pkg::KReport;
          tkey = key_q; tts = offset_q;
          tst  = (key_q == 32'd0) ? tpt_pkg::StSummary : tpt_pkg::StNone;
          tcnt = 16'(occ_q);
        end
      end
    endcase
    // A report normally shows the slot after the state change, with its count bumped.
    // A beacon that moves a slot on reports the slot as it stood before the move.
    if (rep && !nomaster) begin
      ncnt = ncnt + 16'd1;
      kind = tpt_pkg::KReport;
      tkey = nkey; tts = nev + offset_q; tst = nst; tcnt = ncnt;
    end else if (pre_rep && !nomaster) begin
      kind = tpt_pkg::KReport;
      tkey = wkey_q; tts = wev_q + offset_q; tst = wst_q; tcnt = wcnt_q + 16'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      ovalid_q <= 1'b0;
      local_q  <= 16'd1;
      master_q <= 16'd1;
      offset_q <= 32'd0;
      gran_q   <= 16'd10;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          tpt_pkg::RegLocal:   local_q  <= cfg_data_i[15:0];
          tpt_pkg::RegMaster:  master_q <= cfg_data_i[15:0];
          tpt_pkg::RegOffset:  offset_q <= cfg_data_i;
          tpt_pkg::RegGranule: gran_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) ovalid_q <= 1'b0;
      if (state_q == tpt_pkg::S_ACT && wr_en) vld_q[widx] <= !do_clear;
      if (state_q == tpt_pkg::S_OUT && (!ovalid_q || out_ready_i)) ovalid_q <= 1'b1;
    end
  end

  // Slot payload, sequencing registers and result register.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      tpt_pkg::S_IDLE: begin
        mode_q <= mode_i; now_q <= now_seconds_i; key_q <= in_key;
        mask_q <= in_mask; sidx_q <= slot_index_i;
        ptr_q <= '0; occ_q <= '0; found_q <= 1'b0; free_q <= 1'b0;
        fidx_q <= '0; freeidx_q <= '0;
      end
      tpt_pkg::S_SCAN: begin
        if (!found_q && (rkey & mask_q) == key_q) begin
          found_q <= 1'b1; fidx_q <= ptr_q;
        end
        if (!free_q && rkey == 32'd0) begin
          free_q <= 1'b1; freeidx_q <= ptr_q;
        end
        if (rkey != 32'd0) occ_q <= occ_q + CW'(1);
        if (!last_slot) ptr_q <= ptr_q + IW'(1);
      end
      tpt_pkg::S_LOAD: begin
        if (vld_q[widx]) begin
          wkey_q <= key_mem[widx]; wst_q <= st_mem[widx]; wcnt_q <= cnt_mem[widx];
          wev_q <= ev_mem[widx]; wlast_q <= last_mem[widx];
        end else begin
          wkey_q <= '0; wst_q <= '0; wcnt_q <= '0; wev_q <= '0; wlast_q <= '0;
        end
      end
      tpt_pkg::S_ACT: begin
        if (wr_en) begin
          key_mem[widx] <= nkey; st_mem[widx] <= nst; cnt_mem[widx] <= ncnt;
          ev_mem[widx] <= nev; last_mem[widx] <= nlast;
        end
        okind_q <= kind; okey_q <= tkey; ots_q <= tts; ost_q <= tst; ocnt_q <= tcnt;
      end
      default: ;
    endcase
  end

  // The result is held in S_OUT until the output register is free, then moves into view.
  logic [2:0]  vkind_q, vst_q;
  logic [31:0] vkey_q, vts_q;
  logic [15:0] vcnt_q;
  always_ff @(posedge clk_i) begin
    if (state_q == tpt_pkg::S_OUT && (!ovalid_q || out_ready_i)) begin
      vkind_q <= okind_q; vkey_q <= okey_q; vts_q <= ots_q;
      vst_q <= ost_q; vcnt_q <= ocnt_q;
    end
  end

  assign out_valid_o        = ovalid_q;
  assign result_kind_o      = vkind_q;
  assign report_tag_key_o   = vkey_q;
  assign report_timestamp_o = vts_q;
  assign report_state_o     = vst_q;
  assign report_count_o     = vcnt_q;
endmodule

// ----- rtl/tpt_checker.sv -----
// Port checker of the tag presence tracker, bound to the top level.
`include "tag_presence_tracker_top_assert.svh"
module tpt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  result_kind_o,
  input logic [31:0] report_tag_key_o,
  input logic [2:0]  report_state_o
);
  // Results other than a report carry zero fields.
  `TPT_ASSERT_IMPL(a_zero_fields, clk_i, rst_ni,
    out_valid_o && result_kind_o != tpt_pkg::KReport,
    report_tag_key_o == 32'd0 && report_state_o == tpt_pkg::StNone)
  // The kind code stays in its range.
  `TPT_ASSERT_IMPL(a_kind_range, clk_i, rst_ni, out_valid_o,
    result_kind_o <= tpt_pkg::KEmpty)
  // After an item is taken the block is busy.
  `TPT_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // A result waiting unaccepted stays.
  `TPT_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    out_valid_o && $stable(result_kind_o))
endmodule

bind tag_presence_tracker_top tpt_checker u_tpt_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
  .result_kind_o(result_kind_o), .report_tag_key_o(report_tag_key_o),
  .report_state_o(report_state_o)
);

// ----- tb/tag_presence_tracker_top_tb.sv -----
// Self-checking testbench of the tag presence tracker with a built-in slot table predictor.
`timescale 1ns / 1ps

module tag_presence_tracker_top_tb;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] now_s;
    logic [7:0]  rssi;
    logic [7:0]  level;
    logic [15:0] addr;
    logic [31:0] key;
    logic [7:0]  slot;
  } beacon_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] tag_key;
    logic [31:0] stamp;
    logic [2:0]  state;
    logic [15:0] count;
  } tracker_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic [31:0] now_seconds_i = '0;
  logic [7:0]  rssi_i = '0;
  logic [7:0]  power_level_i = '0;
  logic [15:0] tag_address_i = '0;
  logic [31:0] lookup_key_i = '0;
  logic [7:0]  slot_index_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  result_kind_o;
  logic [31:0] report_tag_key_o;
  logic [31:0] report_timestamp_o;
  logic [2:0]  report_state_o;
  logic [15:0] report_count_o;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;

  tag_presence_tracker_top dut (.*);

  always #1 clk_i = ~clk_i;

  // Predictor copy of the configuration and slot table.
  logic [15:0] p_local, p_master, p_granule;
  logic [31:0] p_offset;
  logic [31:0] t_key   [tpt_pkg::TagSlots];
  logic [2:0]  t_state [tpt_pkg::TagSlots];
  logic [15:0] t_count [tpt_pkg::TagSlots];
  logic [31:0] t_event [tpt_pkg::TagSlots];
  logic [31:0] t_last  [tpt_pkg::TagSlots];

  beacon_item_t    pending_items[$];
  tracker_result_t expected_results[$];
  int  errors = 0;
  int  n_results = 0;
  int  n_reports = 0;
  bit  hold_sender = 1'b0;
  int  send_gap = 0;
  int  recv_gap = 0;
  logic [31:0] clock_s = 32'd1000;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int find_slot(logic [31:0] k);
    logic [31:0] m;
    m = tpt_pkg::KeyAll;
    if ((k & tpt_pkg::KeyRssiBits) == 0) m &= tpt_pkg::KeyNoRssi;
    if ((k & tpt_pkg::KeyLevelBits) == 0) m &= tpt_pkg::KeyNoLevel;
    for (int i = 0; i < tpt_pkg::TagSlots; i++)
      if ((t_key[i] & m) == k) return i;
    return -1;
  endfunction

  task automatic wipe_slot(int i);
    t_key[i] = '0; t_state[i] = tpt_pkg::StNone; t_count[i] = '0;
    t_event[i] = '0; t_last[i] = '0;
  endtask

  task automatic shift_state(int i, logic [2:0] st, logic [31:0] now, bit stamp);
    t_state[i] = st; t_count[i] = '0; t_last[i] = now;
    if (stamp) t_event[i] = now;
  endtask

  // A slot report; with no master it is dropped and the count stays.
  task automatic report_slot(int i, ref tracker_result_t r);
    if (p_master == 0) return;
    t_count[i]++;
    r = '{tpt_pkg::KReport, t_key[i], t_event[i] + p_offset, t_state[i], t_count[i]};
  endtask

  task automatic predict_tracker(beacon_item_t it);
    tracker_result_t r;
    logic [31:0] k;
    int f, n;
    r = '0;
    r.kind = tpt_pkg::KNothing;
    case (it.mode)
      tpt_pkg::ModeBeacon: begin
        k = {it.rssi, it.level, it.addr};
        f = find_slot(k);
        if (f < 0) begin
          r.kind = tpt_pkg::KFull;
          for (int i = 0; i < tpt_pkg::TagSlots; i++)
            if (t_key[i] == 0) begin
              t_key[i] = k;
              shift_state(i, tpt_pkg::StNew, it.now_s, 1);
              r.kind = tpt_pkg::KNothing;
              break;
            end
        end else begin
          case (t_state[f])
            tpt_pkg::StNew: begin
              report_slot(f, r);
              shift_state(f, (p_master == p_local) ? tpt_pkg::StConf : tpt_pkg::StReported,
                          it.now_s, 0);
            end
            tpt_pkg::StReported: begin
              t_last[f] = it.now_s;
              report_slot(f, r);
              if (p_master == p_local) shift_state(f, tpt_pkg::StConf, it.now_s, 0);
            end
            tpt_pkg::StConf: t_last[f] = it.now_s;
            tpt_pkg::StFadeRep: shift_state(f, tpt_pkg::StReported, it.now_s, 0);
            tpt_pkg::StFadeConf: shift_state(f, tpt_pkg::StConf, it.now_s, 0);
            tpt_pkg::StGone: shift_state(f, tpt_pkg::StNew, it.now_s, 1);
            default: r.kind = tpt_pkg::KEmpty;
          endcase
        end
      end
      tpt_pkg::ModeAge: begin
        f = it.slot;
        if (f >= tpt_pkg::TagSlots) r.kind = tpt_pkg::KBadSlot;
        else if (t_key[f] != 0 && (it.now_s - t_last[f]) >= {16'd0, p_granule}) begin
          case (t_state[f])
            tpt_pkg::StNew: wipe_slot(f);
            tpt_pkg::StGone: report_slot(f, r);
            tpt_pkg::StReported: shift_state(f, tpt_pkg::StFadeRep, it.now_s, 0);
            tpt_pkg::StConf: shift_state(f, tpt_pkg::StFadeConf, it.now_s, 0);
            tpt_pkg::StFadeRep, tpt_pkg::StFadeConf: begin
              shift_state(f, tpt_pkg::StGone, it.now_s, 1);
              report_slot(f, r);
              if (p_local == p_master || p_master == 0) wipe_slot(f);
            end
            default: r.kind = tpt_pkg::KEmpty;
          endcase
        end
      end
      tpt_pkg::ModeAck: begin
        f = find_slot(it.key);
        if (f >= 0) begin
          if (t_state[f] == tpt_pkg::StReported)
            shift_state(f, tpt_pkg::StConf, it.now_s, 0);
          else if (t_state[f] == tpt_pkg::StFadeRep)
            shift_state(f, tpt_pkg::StFadeConf, it.now_s, 0);
          else if (t_state[f] == tpt_pkg::StGone) wipe_slot(f);
        end
      end
      default: begin
        f = (it.key != 0) ? find_slot(it.key) : -1;
        if (f >= 0) report_slot(f, r);
        else if (p_master != 0) begin
          n = 0;
          for (int i = 0; i < tpt_pkg::TagSlots; i++) if (t_key[i] != 0) n++;
          r = '{tpt_pkg::KReport, it.key, p_offset,
                (it.key == 0) ? tpt_pkg::StSummary : tpt_pkg::StNone, 16'(n)};
        end
      end
    endcase
    expected_results.push_back(r);
  endtask

  // Driver.
  bit sent_last;
  always @(negedge clk_i) begin
    beacon_item_t it;
    if (rst_ni) begin
      if (in_valid_i && !sent_last) begin
        // Still waiting for acceptance; hold.
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!hold_sender && pending_items.size() > 0) begin
        it = pending_items.pop_front();
        predict_tracker(it);
        in_valid_i <= 1'b1;
        mode_i <= it.mode; now_seconds_i <= it.now_s; rssi_i <= it.rssi;
        power_level_i <= it.level; tag_address_i <= it.addr;
        lookup_key_i <= it.key; slot_index_i <= it.slot;
        send_gap <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
      recv_gap = (recv_gap > 0) ? recv_gap - 1 : 0;
      if (recv_gap == 0 && $urandom_range(0, 99) < 25) recv_gap = pick_gap();
      out_ready_i <= (recv_gap == 0);
    end
  end

  // Flags acceptance so the driver at the following falling edge may move on.
  always @(posedge clk_i) sent_last <= in_valid_i && in_ready_o;

  // Monitor.
  always @(posedge clk_i) begin
    tracker_result_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: kind %0d", result_kind_o);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (e.kind == tpt_pkg::KReport) n_reports++;
        if (result_kind_o !== e.kind) begin
          $error("result_kind expected %0d got %0d", e.kind, result_kind_o); errors++;
        end
        if (report_tag_key_o !== e.tag_key) begin
          $error("report_tag_key expected %h got %h", e.tag_key, report_tag_key_o);
          errors++;
        end
        if (report_timestamp_o !== e.stamp) begin
          $error("report_timestamp expected %h got %h", e.stamp, report_timestamp_o);
          errors++;
        end
        if (report_state_o !== e.state) begin
          $error("report_state expected %0d got %0d", e.state, report_state_o); errors++;
        end
        if (report_count_o !== e.count) begin
          $error("report_count expected %0d got %0d", e.count, report_count_o); errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (30) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tpt_pkg::RegLocal:   p_local = val[15:0];
      tpt_pkg::RegMaster:  p_master = val[15:0];
      tpt_pkg::RegOffset:  p_offset = val;
      default:             p_granule = val[15:0];
    endcase
  endtask

  function automatic beacon_item_t make_item(logic [1:0] m, logic [31:0] k, logic [7:0] s);
    beacon_item_t it;
    it.mode = m; it.now_s = clock_s;
    {it.rssi, it.level, it.addr} = k;
    it.key = k; it.slot = s;
    return it;
  endfunction

  // Keys drawn from a small pool so that tags recur and go through their states.
  function automatic logic [31:0] pool_key();
    logic [31:0] k;
    k = {8'($urandom_range(1, 3)), 8'($urandom_range(1, 2)),
         16'($urandom_range(1, 12))};
    if ($urandom_range(0, 19) == 0) k = $urandom;
    if ($urandom_range(0, 9) == 0) k[31:24] = '0;
    if ($urandom_range(0, 9) == 0) k[23:16] = '0;
    return k;
  endfunction

  task automatic random_phase(int n);
    beacon_item_t it;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) clock_s += $urandom_range(0, 3 * p_granule + 5);
      else clock_s += $urandom_range(0, 2);
      if ($urandom_range(0, 199) == 0) clock_s = $urandom;
      if (r < 45) it = make_item(tpt_pkg::ModeBeacon, pool_key(), '0);
      else if (r < 75) it = make_item(tpt_pkg::ModeAge, '0,
                                       ($urandom_range(0, 19) == 0) ? 8'($urandom)
                                       : 8'($urandom_range(0, tpt_pkg::TagSlots - 1)));
      else if (r < 87) it = make_item(tpt_pkg::ModeAck, pool_key(), '0);
      else it = make_item(tpt_pkg::ModeQuery,
                          ($urandom_range(0, 5) == 0) ? '0 : pool_key(), '0);
      // Scramble fields the chosen operation does not use.
      if (it.mode != tpt_pkg::ModeBeacon) {it.rssi, it.level, it.addr} = $urandom;
      if (it.mode == tpt_pkg::ModeBeacon) it.key = $urandom;
      if (it.mode != tpt_pkg::ModeAge) it.slot = $urandom;
      pending_items.push_back(it);
    end
  endtask

  initial begin
    p_local = 16'd1; p_master = 16'd1; p_offset = '0; p_granule = 16'd10;
    for (int i = 0; i < tpt_pkg::TagSlots; i++) wipe_slot(i);
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // Directed: fill the table, overflow it, walk one tag and the special cases.
    pending_items.push_back(make_item(tpt_pkg::ModeBeacon, 32'h0, '0));
    for (int i = 0; i < tpt_pkg::TagSlots; i++)
      pending_items.push_back(make_item(tpt_pkg::ModeBeacon, {8'hff, 8'hff, 16'(i + 1)}, '0));
    pending_items.push_back(make_item(tpt_pkg::ModeBeacon, 32'h0102_0304, '0));
    pending_items.push_back(make_item(tpt_pkg::ModeBeacon, {8'hff, 8'hff, 16'd1}, '0));
    pending_items.push_back(make_item(tpt_pkg::ModeQuery, 32'h0000_0001, '0));
    pending_items.push_back(make_item(tpt_pkg::ModeQuery, 32'h0, '0));
    pending_items.push_back(make_item(tpt_pkg::ModeAck, {8'hff, 8'hff, 16'd1}, '0));
    pending_items.push_back(make_item(tpt_pkg::ModeAge, '0, 8'hff));
    pending_items.push_back(make_item(tpt_pkg::ModeAge, '0, 8'd0));
    clock_s = 32'hffff_fffe;
    pending_items.push_back(make_item(tpt_pkg::ModeAge, '0, 8'd2));
    hold_sender = 1'b0;
    wait_drained();

    write_reg(tpt_pkg::RegLocal, 32'd5);
    write_reg(tpt_pkg::RegMaster, 32'd7);
    write_reg(tpt_pkg::RegOffset, 32'h8000_0000);
    write_reg(tpt_pkg::RegGranule, 32'd0);
    random_phase(400);
    wait_drained();

    write_reg(tpt_pkg::RegMaster, 32'd0);
    write_reg(tpt_pkg::RegGranule, 32'hffff);
    write_reg(tpt_pkg::RegOffset, 32'h7fff_ffff);
    random_phase(250);
    wait_drained();

    write_reg(tpt_pkg::RegLocal, 32'hffff);
    write_reg(tpt_pkg::RegMaster, 32'hffff);
    write_reg(tpt_pkg::RegGranule, 32'd4);
    write_reg(tpt_pkg::RegOffset, 32'hffff_fff0);
    random_phase(500);
    // Part way through, the sender stops until every outstanding result is back.
    while (pending_items.size() > 250) @(posedge clk_i);
    hold_sender = 1'b1;
    while (expected_results.size() > 0) @(posedge clk_i);
    hold_sender = 1'b0;
    random_phase(1);
    wait_drained();

    write_reg(tpt_pkg::RegLocal, 32'd0);
    write_reg(tpt_pkg::RegMaster, 32'd3);
    write_reg(tpt_pkg::RegGranule, 32'd10);
    write_reg(tpt_pkg::RegOffset, 32'd0);
    random_phase(550);
    wait_drained();

    $display("Checked %0d results (%0d reports) over five register settings.",
             n_results, n_reports);
    if (errors == 0) $display("tag_presence_tracker_top_tb passed");
    else $display("tag_presence_tracker_top_tb failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("tag_presence_tracker_top_tb failed");
    $finish;
  end
endmodule
